// ===== rtl/fpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int BLOCKS_DEF    = 16;
	localparam int SIZE_BITS_DEF = 16;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_FIT_MODE      = 1'b0;
	localparam logic REG_ACTIVE_BLOCKS = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] FIT_MODE_RST      = FIT_FIRST;
	localparam logic [4:0] ACTIVE_BLOCKS_RST = 5'd16;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef struct packed {
		logic        command;
		logic [3:0]  block_slot;
		logic [15:0] amount;
	} item_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_block;
		logic [15:0] left_over;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/fpba_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface fpba_item_if;
	import fpba_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fpba_result_if;
	import fpba_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fpba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cell
// One block entry: holds its capacity and refines the running candidate
// handed over from the previous cell.
// ----------------------------------------------------------------------------
module fpba_cell #(
	parameter int INDEX     = 0,
	parameter int IDX_W     = 4,
	parameter int SIZE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           mode,
	input  logic                 en,
	input  logic [SIZE_BITS-1:0] amt,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_idx,
	input  logic [SIZE_BITS-1:0] wr_val,
	input  logic                 prev_found,
	input  logic [IDX_W-1:0]     prev_idx,
	input  logic [SIZE_BITS-1:0] prev_cap,
	output logic                 found,
	output logic [IDX_W-1:0]     idx,
	output logic [SIZE_BITS-1:0] cap
);
	import fpba_pkg::*;

	logic [SIZE_BITS-1:0] cap_q;
	logic                 found_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] cand_cap_q;
	logic                 fits;
	logic                 better;
	logic                 take;

	always_comb begin
		fits = en && (cap_q >= amt);
		unique case (mode)
			FIT_BEST:  better = cap_q < prev_cap;
			FIT_WORST: better = cap_q > prev_cap;
			default:   better = 1'b0;
		endcase
		// ties keep the lower index already in the candidate
		take = fits && (!prev_found || better);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
			cap_q <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= prev_found | take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q      <= IDX_W'(INDEX);
			cand_cap_q <= cap_q;
		end else begin
			idx_q      <= prev_idx;
			cand_cap_q <= prev_cap;
		end
	end

	assign found = found_q;
	assign idx   = idx_q;
	assign cap   = cand_cap_q;

endmodule

// ===== rtl/fit_policy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// First, best and worst fit allocator over a row of block cells.
// Flow: an accepted allocate moves to ST_SCAN while the candidate ripples
//   through the cell row, then to ST_DONE, where the result is registered once
//   the result channel is free; requests, loads among them, are taken only in ST_IDLE.
// Reset: all capacities clear to zero, fit_mode to first fit, active_blocks
//   to 16, no result pending.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core #(
	parameter int BLOCKS    = fpba_pkg::BLOCKS_DEF,
	parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fpba_item_if.sink                   item,
	fpba_result_if.source               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fpba_pkg::ADDR_W-1:0] paddr,
	input  logic [fpba_pkg::DATA_W-1:0] pwdata,
	output logic [fpba_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import fpba_pkg::*;

	localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int CNT_W = $clog2(BLOCKS + 1);

	state_t state_q, state_d;

	logic [1:0]           fit_mode_q;
	logic [4:0]           active_q;
	logic [SIZE_BITS-1:0] amt_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 res_valid_q;
	result_t              res_q;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_idx;
	logic [SIZE_BITS-1:0] wr_val;
	logic                 res_load;
	logic                 slot_ok;
	logic                 cfg_wr;
	logic [SIZE_BITS-1:0] new_cap;

	logic                 chain_found [0:BLOCKS];
	logic [IDX_W-1:0]     chain_idx   [0:BLOCKS];
	logic [SIZE_BITS-1:0] chain_cap   [0:BLOCKS];

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_MODE_RST;
			active_q   <= ACTIVE_BLOCKS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FIT_MODE:      fit_mode_q <= pwdata[1:0];
				REG_ACTIVE_BLOCKS: active_q   <= pwdata[4:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIT_MODE:      prdata = {(DATA_W-2)'(0), fit_mode_q};
			REG_ACTIVE_BLOCKS: prdata = {(DATA_W-5)'(0), active_q};
		endcase
	end

	// cell row, seeded with an empty candidate
	assign chain_found[0] = 1'b0;
	assign chain_idx[0]   = '0;
	assign chain_cap[0]   = '0;

	for (genvar j = 0; j < BLOCKS; j++) begin : g_cell
		logic cell_en;
		assign cell_en = j < int'(active_q);

		fpba_cell #(
			.INDEX     (j),
			.IDX_W     (IDX_W),
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.mode       (fit_mode_q),
			.en         (cell_en),
			.amt        (amt_q),
			.wr_en      (wr_en),
			.wr_idx     (wr_idx),
			.wr_val     (wr_val),
			.prev_found (chain_found[j]),
			.prev_idx   (chain_idx[j]),
			.prev_cap   (chain_cap[j]),
			.found      (chain_found[j+1]),
			.idx        (chain_idx[j+1]),
			.cap        (chain_cap[j+1])
		);
	end

	assign slot_ok = int'(item.data.block_slot) < BLOCKS;
	assign new_cap = chain_cap[BLOCKS] - amt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		wr_en      = 1'b0;
		wr_idx     = '0;
		wr_val     = '0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (item.data.command == CMD_ALLOC) begin
						state_d = ST_SCAN;
					end else if (slot_ok) begin
						wr_en  = 1'b1;
						wr_idx = IDX_W'(item.data.block_slot);
						wr_val = SIZE_BITS'(item.data.amount);
					end
				end
			end
			ST_SCAN: begin
				// the tail is settled once the candidate crossed every cell
				if (cnt_q == CNT_W'(BLOCKS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || result.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					wr_en    = chain_found[BLOCKS];
					wr_idx   = chain_idx[BLOCKS];
					wr_val   = new_cap;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready && (item.data.command == CMD_ALLOC)) begin
			amt_q <= SIZE_BITS'(item.data.amount);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.granted <= chain_found[BLOCKS];
			if (chain_found[BLOCKS]) begin
				res_q.chosen_block <= 4'(chain_idx[BLOCKS]);
				res_q.left_over    <= 16'(new_cap);
			end else begin
				res_q.chosen_block <= '0;
				res_q.left_over    <= '0;
			end
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule

// ===== rtl/fpba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_command,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_granted,
	input logic [3:0]  res_chosen_block,
	input logic [15:0] res_left_over
);
	import fpba_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_granted)
			&& $stable(res_chosen_block) && $stable(res_left_over))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_granted |-> res_chosen_block == 4'd0 && res_left_over == 16'd0)
		else $error("failed request carries nonzero fields");

	// an allocate request occupies the block while it scans
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_command == CMD_ALLOC |=> !item_ready)
		else $error("request taken during a scan");

	a_res_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(item_ready))
		else $error("result appeared without a scan");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.item_command     (item.data.command),
	.res_valid        (result.valid),
	.res_ready        (result.ready),
	.res_granted      (result.data.granted),
	.res_chosen_block (result.data.chosen_block),
	.res_left_over    (result.data.left_over)
);
